// ===== sv/iac_pkg.sv =====
`timescale 1ns / 1ps

package iac_pkg;

  localparam int unsigned InWidth  = 72;
  localparam int unsigned OutWidth = 40;

  typedef enum logic [2:0] {
    CFG_AUTH_UID   = 3'd0,
    CFG_NEAR_LIMIT = 3'd1,
    CFG_FAR_LIMIT  = 3'd2,
    CFG_DARK_THR   = 3'd3,
    CFG_AUTH_TICKS = 3'd4,
    CFG_COOL_TICKS = 3'd5
  } cfg_index_e;

  typedef enum logic [2:0] {
    STAT_OFF    = 3'd0,
    STAT_AUTH   = 3'd1,
    STAT_ALARM  = 3'd2,
    STAT_DOOR   = 3'd3,
    STAT_OBJECT = 3'd4,
    STAT_READY  = 3'd5
  } disp_status_e;

  typedef enum logic [1:0] {
    ECHO_OK        = 2'd0,
    ECHO_NO_START  = 2'd1,
    ECHO_TOO_LONG  = 2'd2,
    ECHO_UNDEFINED = 2'd3
  } echo_status_e;

  localparam logic [2:0] SndArm     = 3'b001;
  localparam logic [2:0] SndDisarm  = 3'b010;
  localparam logic [2:0] SndConfirm = 3'b100;

  localparam logic [15:0] BarLow  = 16'h00FF;
  localparam logic [15:0] BarHigh = 16'hFF00;

  localparam logic [31:0] UidReset       = 32'd213521323;
  localparam logic [14:0] NearReset      = 15'd500;
  localparam logic [14:0] FarReset       = 15'd20000;
  localparam logic [15:0] DarkReset      = 16'd30;
  localparam logic [7:0]  AuthTicksReset = 8'd100;
  localparam logic [7:0]  CoolTicksReset = 8'd30;

  // (x + 9) / 10 as ((x + 9) * 205) >> 11, exact for x + 9 below 1029
  localparam logic [8:0]  SecRound = 9'd9;
  localparam logic [16:0] SecRecip = 17'd205;

  typedef struct packed {
    logic [15:0] light_level;
    logic        door_open;
    logic [14:0] echo_width;
    logic [1:0]  echo_status;
    logic [31:0] card_uid;
    logic        card_present;
    logic        joy_center;
    logic        joy_active;
  } in_item_t;

  typedef struct packed {
    logic        invert_display;
    logic [4:0]  auth_seconds;
    logic [2:0]  display_status;
    logic        refresh;
    logic [2:0]  sound_mask;
    logic        motion_seen;
    logic [15:0] led_bar;
    logic        alarm_active;
    logic        authorized_now;
    logic        armed_now;
  } out_item_t;

endpackage

// ===== sv/intrusion_alarm_controller_unit.sv =====
`timescale 1ns / 1ps

// Alarm panel controller, one item per 100 ms tick. An accepted item is held
// in an input register; from there flag and counter logic updates the panel
// state and loads the result register. A new item is taken in every cycle
// while results are taken; each result is offered from the result register,
// and the input stage waits only while the result register is full and not
// taken. The user must write configuration registers only while the block is
// idle; the block itself does not enforce this. The phase periods for motion
// sampling, light checks and display redraw are module parameters.
module intrusion_alarm_controller_unit #(
  parameter int unsigned MOTION_PERIOD  = 3,
  parameter int unsigned LIGHT_PERIOD   = 31,
  parameter int unsigned DISPLAY_PERIOD = 6
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // joy_active, joy_center, card_present, card_uid[31:0], echo_status[1:0],
  // echo_width[14:0], door_open, light_level[15:0], zero pad
  input  logic [iac_pkg::InWidth-1:0]  s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // armed_now, authorized_now, alarm_active, led_bar[15:0], motion_seen,
  // sound_mask[2:0], refresh, display_status[2:0], auth_seconds[4:0],
  // invert_display, zero pad
  output logic [iac_pkg::OutWidth-1:0] m_axis_tdata_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned MpW = (MOTION_PERIOD > 1) ? $clog2(MOTION_PERIOD) : 1;
  localparam int unsigned LpW = (LIGHT_PERIOD > 1) ? $clog2(LIGHT_PERIOD) : 1;
  localparam int unsigned DpW = (DISPLAY_PERIOD > 1) ? $clog2(DISPLAY_PERIOD) : 1;
  localparam logic [MpW-1:0] MotionLast  = MpW'(MOTION_PERIOD - 1);
  localparam logic [LpW-1:0] LightLast   = LpW'(LIGHT_PERIOD - 1);
  localparam logic [DpW-1:0] DisplayLast = DpW'(DISPLAY_PERIOD - 1);

  logic [31:0] uid_q;
  logic [14:0] near_q, far_q;
  logic [15:0] dark_q;
  logic [7:0]  auth_ticks_q, cool_ticks_q;

  logic               in_valid_q, out_valid_q;
  iac_pkg::in_item_t  in_q;
  iac_pkg::out_item_t out_q, out_d;
  logic               advance;

  logic           armed_q, armed_d;
  logic           authorized_q, authorized_d;
  logic           card_seen_q, card_seen_d;
  logic [7:0]     auth_left_q, auth_left_d;
  logic           motion_q, motion_d;
  logic [7:0]     cool_left_q, cool_left_d;
  logic           latched_q, latched_d;
  logic [MpW-1:0] motion_ph_q, motion_ph_d;
  logic [LpW-1:0] light_ph_q, light_ph_d;
  logic [DpW-1:0] disp_ph_q, disp_ph_d;
  logic           inverted_q, inverted_d;
  logic           bar_q, bar_d;

  logic        match, alarm_on, in_range;
  logic [16:0] sec_prod;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      uid_q        <= iac_pkg::UidReset;
      near_q       <= iac_pkg::NearReset;
      far_q        <= iac_pkg::FarReset;
      dark_q       <= iac_pkg::DarkReset;
      auth_ticks_q <= iac_pkg::AuthTicksReset;
      cool_ticks_q <= iac_pkg::CoolTicksReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        iac_pkg::CFG_AUTH_UID:   uid_q        <= cfg_data_i;
        iac_pkg::CFG_NEAR_LIMIT: near_q       <= cfg_data_i[14:0];
        iac_pkg::CFG_FAR_LIMIT:  far_q        <= cfg_data_i[14:0];
        iac_pkg::CFG_DARK_THR:   dark_q       <= cfg_data_i[15:0];
        iac_pkg::CFG_AUTH_TICKS: auth_ticks_q <= cfg_data_i[7:0];
        iac_pkg::CFG_COOL_TICKS: cool_ticks_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(iac_pkg::OutWidth - $bits(iac_pkg::out_item_t)){1'b0}}, out_q};

  always_comb begin
    armed_d      = armed_q;
    authorized_d = authorized_q;
    card_seen_d  = card_seen_q;
    auth_left_d  = auth_left_q;
    motion_d     = motion_q;
    cool_left_d  = cool_left_q;
    latched_d    = latched_q;
    motion_ph_d  = motion_ph_q;
    light_ph_d   = light_ph_q;
    disp_ph_d    = disp_ph_q;
    inverted_d   = inverted_q;
    bar_d        = bar_q;
    out_d        = '0;
    match        = 1'b0;
    in_range     = 1'b0;
    sec_prod     = '0;

    if (in_q.joy_active || in_q.joy_center) begin
      if (in_q.joy_center) begin
        out_d.sound_mask = armed_q ? iac_pkg::SndDisarm : iac_pkg::SndArm;
        armed_d      = !armed_q;
        authorized_d = 1'b0;
        motion_d     = 1'b0;
        cool_left_d  = '0;
        latched_d    = 1'b0;
      end
      disp_ph_d = '0;
    end

    if (light_ph_q >= LightLast) begin
      light_ph_d = '0;
      inverted_d = in_q.light_level <= dark_q;
    end else begin
      light_ph_d = light_ph_q + 1'b1;
    end

    if (armed_d) begin
      match = in_q.card_present && (in_q.card_uid == uid_q);
      if (match && !card_seen_q) begin
        authorized_d = 1'b1;
        auth_left_d  = auth_ticks_q;
        motion_d     = 1'b0;
        cool_left_d  = '0;
        latched_d    = 1'b0;
        out_d.sound_mask = out_d.sound_mask | iac_pkg::SndConfirm;
        disp_ph_d    = '0;
      end
      card_seen_d = match;

      if (authorized_d && auth_left_d != '0) begin
        auth_left_d = auth_left_d - 8'd1;
        if (auth_left_d == '0) begin
          authorized_d = 1'b0;
          disp_ph_d    = '0;
        end
      end

      if (motion_ph_q >= MotionLast) begin
        motion_ph_d = '0;
        in_range = (in_q.echo_status == iac_pkg::ECHO_OK) &&
                   (in_q.echo_width >= near_q) && (in_q.echo_width < far_q);
        if (in_range) begin
          motion_d    = 1'b1;
          cool_left_d = cool_ticks_q;
          if (!authorized_d) latched_d = 1'b1;
          disp_ph_d   = '0;
        end
      end else begin
        motion_ph_d = motion_ph_q + 1'b1;
      end

      if (in_q.door_open && !authorized_d && !latched_d) begin
        latched_d = 1'b1;
        disp_ph_d = '0;
      end

      if (cool_left_d != '0) begin
        cool_left_d = cool_left_d - 8'd1;
        if (cool_left_d == '0) begin
          motion_d  = 1'b0;
          disp_ph_d = '0;
        end
      end
    end else begin
      authorized_d = 1'b0;
      motion_d     = 1'b0;
      cool_left_d  = '0;
      latched_d    = 1'b0;
      card_seen_d  = 1'b0;
      auth_left_d  = '0;
      motion_ph_d  = '0;
    end

    if (disp_ph_d >= DisplayLast) begin
      disp_ph_d     = '0;
      out_d.refresh = 1'b1;
      if (!armed_d) begin
        out_d.display_status = iac_pkg::STAT_OFF;
      end else if (authorized_d) begin
        out_d.display_status = iac_pkg::STAT_AUTH;
        sec_prod = (17'({1'b0, auth_left_d}) + 17'(iac_pkg::SecRound)) * iac_pkg::SecRecip;
        out_d.auth_seconds = sec_prod[15:11];
      end else if (latched_d) begin
        out_d.display_status = iac_pkg::STAT_ALARM;
      end else if (in_q.door_open) begin
        out_d.display_status = iac_pkg::STAT_DOOR;
      end else if (motion_d && cool_left_d != '0) begin
        out_d.display_status = iac_pkg::STAT_OBJECT;
      end else begin
        out_d.display_status = iac_pkg::STAT_READY;
      end
    end else begin
      disp_ph_d = disp_ph_d + 1'b1;
    end

    alarm_on = armed_d && !authorized_d && latched_d;
    if (alarm_on) begin
      out_d.led_bar = bar_q ? iac_pkg::BarHigh : iac_pkg::BarLow;
      bar_d = !bar_q;
    end else begin
      bar_d = 1'b0;
    end

    out_d.armed_now      = armed_d;
    out_d.authorized_now = authorized_d;
    out_d.alarm_active   = alarm_on;
    out_d.motion_seen    = motion_d && cool_left_d != '0;
    out_d.invert_display = inverted_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      armed_q      <= 1'b0;
      authorized_q <= 1'b0;
      card_seen_q  <= 1'b0;
      auth_left_q  <= '0;
      motion_q     <= 1'b0;
      cool_left_q  <= '0;
      latched_q    <= 1'b0;
      motion_ph_q  <= '0;
      light_ph_q   <= LightLast;
      disp_ph_q    <= '0;
      inverted_q   <= 1'b0;
      bar_q        <= 1'b0;
    end else begin
      if (s_axis_tready_o) in_valid_q <= s_axis_tvalid_i;
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      if (advance) begin
        armed_q      <= armed_d;
        authorized_q <= authorized_d;
        card_seen_q  <= card_seen_d;
        auth_left_q  <= auth_left_d;
        motion_q     <= motion_d;
        cool_left_q  <= cool_left_d;
        latched_q    <= latched_d;
        motion_ph_q  <= motion_ph_d;
        light_ph_q   <= light_ph_d;
        disp_ph_q    <= disp_ph_d;
        inverted_q   <= inverted_d;
        bar_q        <= bar_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_q <= s_axis_tdata_i[$bits(iac_pkg::in_item_t)-1:0];
    end
    if (advance) out_q <= out_d;
  end

  a_alarm_needs_armed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.alarm_active |-> out_q.armed_now && !out_q.authorized_now)
    else $error("alarm shown while disarmed or authorized");

  a_bar_follows_alarm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_q.led_bar == '0) == !out_q.alarm_active))
    else $error("led bar out of step with alarm");

  a_seconds_only_auth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.auth_seconds != '0 |->
      out_q.refresh && out_q.display_status == iac_pkg::STAT_AUTH)
    else $error("auth seconds outside an authorized redraw");

  a_disarmed_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !armed_q |-> !authorized_q && !latched_q && auth_left_q == '0 && cool_left_q == '0)
    else $error("activity state left while disarmed");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready_i |=> out_valid_q && $stable(out_q))
    else $error("stalled result changed");

endmodule
